[hdl/pip_pkg.sv]
// Shared types, constants and codes for the even-odd point-in-polygons block.
package pip_pkg;

	// Storage and coordinate sizing.
	localparam int MAX_VERTICES = 256;
	localparam int COORD_BITS   = 16;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int DIFF_W       = COORD_BITS + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [1:0] operation;
		coord_t     coord_x;
		coord_t     coord_y;
		logic       closes_polygon;
	} req_t;

	typedef struct packed {
		logic inside_res;
		logic overflowed;
	} rsp_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vtx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              clear;
		logic              append;
		logic              start;
		logic              rd_en;
		logic              last;
		logic [ADDR_W-1:0] addr;
		logic              load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             done;
	} sts_t;

endpackage

[hdl/pip_edge.sv]
// Two-stage edge crossing test: differences, then cross products and compare.
module pip_edge import pip_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  vtx_t   a,
	input  vtx_t   b,
	input  vtx_t   q,
	output logic   flip
);

	logic                     straddle;
	logic                     left_ok;
	logic signed [DIFF_W-1:0] dyi;
	logic signed [DIFF_W-1:0] dxe;
	logic signed [DIFF_W-1:0] dxi;
	logic signed [DIFF_W-1:0] dy;

	logic                     hit_s2;
	logic                     dy_pos_s2;
	logic signed [DIFF_W-1:0] dyi_s2;
	logic signed [DIFF_W-1:0] dxe_s2;
	logic signed [DIFF_W-1:0] dxi_s2;
	logic signed [DIFF_W-1:0] dy_s2;

	logic                     hit_s3;
	logic                     dy_pos_s3;
	logic signed [PROD_W-1:0] p1_s3;
	logic signed [PROD_W-1:0] p2_s3;

	// The edge must straddle the query y and have one end at or left of the query x.
	always_comb begin
		straddle = ((a.y < q.y) && (b.y >= q.y)) || ((b.y < q.y) && (a.y >= q.y));
		left_ok  = (a.x <= q.x) || (b.x <= q.x);
		dyi      = DIFF_W'(q.y) - DIFF_W'(a.y);
		dxe      = DIFF_W'(b.x) - DIFF_W'(a.x);
		dxi      = DIFF_W'(q.x) - DIFF_W'(a.x);
		dy       = DIFF_W'(b.y) - DIFF_W'(a.y);
	end

	// First stage holds the differences.
	always_ff @(posedge clk) begin
		hit_s2    <= en && straddle && left_ok;
		dy_pos_s2 <= (dy > 0);
		dyi_s2    <= dyi;
		dxe_s2    <= dxe;
		dxi_s2    <= dxi;
		dy_s2     <= dy;
	end

	// Second stage holds the two cross products.
	always_ff @(posedge clk) begin
		hit_s3    <= hit_s2;
		dy_pos_s3 <= dy_pos_s2;
		p1_s3     <= PROD_W'(dyi_s2) * PROD_W'(dxe_s2);
		p2_s3     <= PROD_W'(dxi_s2) * PROD_W'(dy_s2);
	end

	// The crossing lies left of the query when the products compare in the
	// direction given by the sign of the edge's y difference.
	assign flip = hit_s3 && (dy_pos_s3 ? (p1_s3 < p2_s3) : (p1_s3 > p2_s3));

endmodule

[hdl/pip_dp.sv]
// Datapath: vertex memory, polygon walk, parity accumulation and result register.
module pip_dp import pip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp
);

	vtx_t             vtx_mem [MAX_VERTICES];
	logic             end_mem [MAX_VERTICES];

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             full;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] end_addr;
	logic             end_wr;
	logic             end_val;

	vtx_t             query_q;
	vtx_t             rd_vtx_s1;
	logic             rd_end_s1;
	logic             valid_s1;
	logic             last_s1;
	logic             valid_s2;
	logic             last_s2;
	logic             end_s2;
	logic             valid_s3;
	logic             last_s3;
	logic             end_s3;

	vtx_t             prev_q;
	vtx_t             first_q;
	vtx_t             close_b;
	logic             start_q;
	logic             poly_q;
	logic             total_q;
	logic             done_q;
	logic             en_a;
	logic             en_b;
	logic             flip_a;
	logic             flip_b;
	logic             poly_nxt;

	assign full     = (count_q == CNT_W'(MAX_VERTICES));
	assign wr_addr  = count_q[ADDR_W-1:0];

	// An append past capacity may still close the polygon at the last stored vertex.
	always_comb begin
		end_wr   = 1'b0;
		end_addr = wr_addr;
		end_val  = req.closes_polygon;
		if (cmd.append) begin
			if (!full) begin
				end_wr = 1'b1;
			end else if (req.closes_polygon && (count_q != '0)) begin
				end_wr   = 1'b1;
				end_addr = wr_addr - ADDR_W'(1);
				end_val  = 1'b1;
			end
		end
	end

	// Vertex count and sticky overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.append) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Memory writes.
	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			vtx_mem[wr_addr] <= '{x: req.coord_x, y: req.coord_y};
		end
		if (end_wr) begin
			end_mem[end_addr] <= end_val;
		end
	end

	// Registered memory reads during the walk.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_vtx_s1 <= vtx_mem[cmd.addr];
			rd_end_s1 <= end_mem[cmd.addr];
		end
	end

	// Query point, latched when a query transaction is taken.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			query_q <= '{x: req.coord_x, y: req.coord_y};
		end
	end

	// Pipeline control tokens.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			end_s2   <= 1'b0;
			valid_s3 <= 1'b0;
			last_s3  <= 1'b0;
			end_s3   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			last_s1  <= cmd.rd_en && cmd.last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			end_s2   <= valid_s1 && rd_end_s1;
			valid_s3 <= valid_s2;
			last_s3  <= last_s2;
			end_s3   <= end_s2;
			done_q   <= valid_s3 && last_s3;
		end
	end

	// Track the previous vertex and the first vertex of the open polygon.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else if (cmd.start) begin
			start_q <= 1'b1;
		end else if (valid_s1) begin
			start_q <= rd_end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prev_q <= rd_vtx_s1;
			if (start_q) begin
				first_q <= rd_vtx_s1;
			end
		end
	end

	// Edge A joins the previous vertex to this one; edge B closes the polygon.
	assign en_a    = valid_s1 && !start_q;
	assign en_b    = valid_s1 && rd_end_s1;
	assign close_b = start_q ? rd_vtx_s1 : first_q;

	pip_edge u_edge_a (
		.clk  (clk),
		.en   (en_a),
		.a    (prev_q),
		.b    (rd_vtx_s1),
		.q    (query_q),
		.flip (flip_a)
	);

	pip_edge u_edge_b (
		.clk  (clk),
		.en   (en_b),
		.a    (rd_vtx_s1),
		.b    (close_b),
		.q    (query_q),
		.flip (flip_b)
	);

	// Per-polygon parity is folded into the total only when the polygon closes.
	assign poly_nxt = poly_q ^ flip_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q  <= 1'b0;
			total_q <= 1'b0;
		end else if (cmd.start) begin
			poly_q  <= 1'b0;
			total_q <= 1'b0;
		end else if (valid_s3) begin
			if (end_s3) begin
				total_q <= total_q ^ poly_nxt ^ flip_b;
				poly_q  <= 1'b0;
			end else begin
				poly_q  <= poly_nxt;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp <= '{inside_res: total_q, overflowed: ovf_q};
		end
	end

	assign sts = '{count: count_q, done: done_q};

endmodule

[hdl/pip_ctrl.sv]
// Controller: input and output handshakes and the sequencing of the vertex walk.
module pip_ctrl import pip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WALK  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t            state_q;
	state_t            state_nxt;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] addr_nxt;
	logic              accept;
	logic              last_addr;
	logic              out_free;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign last_addr = ((CNT_W'(addr_q) + CNT_W'(1)) == sts.count);
	assign out_free  = !rsp_valid || !rsp_stall;

	// Next state and commands.
	always_comb begin
		state_nxt    = state_q;
		addr_nxt     = addr_q;
		cmd          = '0;
		cmd.addr     = addr_q;
		cmd.last     = last_addr;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.operation)
						OP_CLEAR:  cmd.clear  = 1'b1;
						OP_APPEND: cmd.append = 1'b1;
						OP_QUERY: begin
							cmd.start = 1'b1;
							addr_nxt  = '0;
							state_nxt = (sts.count == '0) ? S_DONE : S_WALK;
						end
						default: ;
					endcase
				end
			end
			S_WALK: begin
				cmd.rd_en = 1'b1;
				addr_nxt  = addr_q + ADDR_W'(1);
				if (last_addr) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (sts.done) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q  <= '0;
		end else begin
			state_q <= state_nxt;
			addr_q  <= addr_nxt;
		end
	end

	// Output valid: set on a load, cleared once the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

`ifndef SYNTH
	// The pipeline reports completion only while the controller waits for it.
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (state_q == S_DRAIN))
		else $error("walk completion outside of drain state");

	// A result is never loaded over one that is still held by the receiver.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(rsp_valid && rsp_stall))
		else $error("result register overwritten while stalled");

	// The walk never reads beyond the stored vertices.
	a_addr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (CNT_W'(addr_q) < sts.count))
		else $error("walk address beyond vertex count");
`endif

endmodule

[hdl/point_in_polygons_even_odd.sv]
// Top level of the even-odd point-in-polygons block.
//
// Usage: the request channel (req_valid, req_stall, req) carries one of three
// operations. Clear empties the vertex store and the overflow flag. Append
// stores one vertex and marks the end of a polygon when closes_polygon is set;
// vertices past capacity are dropped and set the sticky overflow flag. Query
// walks every stored vertex once and returns one transaction on the response
// channel (rsp_valid, rsp_stall, rsp) with the XOR of all polygons' crossing
// parities and the overflow flag. Clear and append produce no response.
// A query holds req_stall while the walk reads one vertex per cycle from the
// single-read-port vertex memory, then while the reads pass the memory read
// register, the edge pipeline and the completion register, and until the
// result register is loaded. With an empty store the query skips the walk
// and holds req_stall only until the result register is loaded.
// The result register decouples the sides: a new request is taken while a
// response waits; a finished query holds until the receiver releases stall.
// After reset the store is empty, the flag is clear and no response is
// pending.
module point_in_polygons_even_odd import pip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	pip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	pip_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
